[design/rtdt_pkg.sv]
package rtdt_pkg;

  localparam int DEF_MAX_WIDTH  = 512;
  localparam int DEF_MAX_HEIGHT = 512;

  // action codes (tuser)
  localparam logic [1:0] ACT_VERTEX  = 2'd0;
  localparam logic [1:0] ACT_ADVANCE = 2'd1;
  localparam logic [1:0] ACT_CLEAR   = 2'd2;

  localparam logic [1:0] LAST_CORNER = 2'd2;

  // configuration register indexes
  localparam logic [1:0] REG_WIDTH  = 2'd0;
  localparam logic [1:0] REG_HEIGHT = 2'd1;
  localparam logic [1:0] REG_FAR    = 2'd2;

  localparam logic [9:0]  SW_RESET  = 10'd512;
  localparam logic [9:0]  SH_RESET  = 10'd512;
  localparam logic [30:0] FAR_RESET = 31'd13107200;

  // datapath widths
  localparam int DET_W = 29;
  localparam int NX_W  = 47;
  localparam int NUM_W = 62;
  localparam int DVD_W = 64;
  localparam int DVS_W = 30;

  typedef enum logic [3:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_SETUP0,
    ST_SETUP1,
    ST_SETUP2,
    ST_PIX0,
    ST_PIX1,
    ST_PIX2,
    ST_PIX3,
    ST_PIX4,
    ST_DIV,
    ST_FIN
  } rtdt_state_t;

endpackage

[design/rtdt_div.sv]
module rtdt_div #(
  parameter int NW = 64,
  parameter int DW = 30
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          start,
  input  logic [NW-1:0] dividend,
  input  logic [DW-1:0] divisor,
  output logic          done,
  output logic [NW-1:0] quotient
);

  localparam int CW = $clog2(NW + 1);

  logic [CW-1:0] cnt_r;
  logic          busy_r;
  logic          done_r;
  logic [NW-1:0] q_r;
  logic [DW-1:0] rem_r;
  logic [DW-1:0] dvs_r;
  logic [DW:0]   rem_sh;
  logic [DW:0]   diff;
  logic          fits;

  // restoring division, one quotient bit per cycle, MSB first
  always_comb begin
    rem_sh = {rem_r, q_r[NW-1]};
    diff   = rem_sh - {1'b0, dvs_r};
    fits   = (rem_sh >= {1'b0, dvs_r});
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= busy_r && (cnt_r == CW'(1));
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= CW'(NW);
      end else if (busy_r) begin
        cnt_r <= cnt_r - CW'(1);
        if (cnt_r == CW'(1)) begin
          busy_r <= 1'b0;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      q_r   <= dividend;
      rem_r <= '0;
      dvs_r <= divisor;
    end else if (busy_r) begin
      q_r   <= {q_r[NW-2:0], fits};
      rem_r <= fits ? diff[DW-1:0] : rem_sh[DW-1:0];
    end
  end

  assign done     = done_r;
  assign quotient = q_r;

endmodule

[design/triangle_raster_depth_test.sv]
// Vertex and clear words are accepted from idle; corner 2 then runs setup states SETUP0, SETUP1, SETUP2.
// Advance words: when the depth plane is sloped, PIX0..PIX4, then the bit-serial divider
// (which dominates), then FIN; when the determinant is zero, PIX0..PIX3, then FIN.
// Clear: one depth store entry per cycle, over all MAX_WIDTH*MAX_HEIGHT entries.
// Reset (rst_n low, synchronous) clears control state and then sweeps the whole
// depth store with the reset far depth (no input taken).
module triangle_raster_depth_test
  import rtdt_pkg::*;
#(
  parameter int MAX_WIDTH  = DEF_MAX_WIDTH,
  parameter int MAX_HEIGHT = DEF_MAX_HEIGHT
) (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         in_tvalid,
  output logic         in_tready,
  // vertex_index, vertex_x, vertex_y, vertex_depth, fill_color, outline_color, outline_on
  input  logic [119:0] in_tdata,
  // action
  input  logic [1:0]   in_tuser,
  output logic         out_tvalid,
  input  logic         out_tready,
  // pixel_x, pixel_y, pixel_color, pixel_depth, write_enable
  output logic [87:0]  out_tdata,
  output logic         out_tlast,
  input  logic         cfg_valid,
  output logic         cfg_ready,
  input  logic [1:0]   cfg_index,
  input  logic [30:0]  cfg_data
);

  localparam int MEM_DEPTH = MAX_WIDTH * MAX_HEIGHT;
  localparam int AW        = $clog2(MEM_DEPTH);
  localparam logic [12:0] MAXW_C = 13'(MAX_WIDTH);
  localparam logic [12:0] MAXH_C = 13'(MAX_HEIGHT);
  localparam logic signed [NUM_W-1:0] ZD_LIM = 62'sd1099511627776;

  // ---------------- configuration ----------------
  logic [9:0]  sw_r, sh_r;
  logic [30:0] far_r;
  logic [9:0]  effw, effh;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sw_r  <= SW_RESET;
      sh_r  <= SH_RESET;
      far_r <= FAR_RESET;
    end else if (cfg_valid) begin
      case (cfg_index)
        REG_WIDTH:  sw_r  <= cfg_data[9:0];
        REG_HEIGHT: sh_r  <= cfg_data[9:0];
        REG_FAR:    far_r <= cfg_data;
        default: ;
      endcase
    end
  end

  assign effw = ({3'b0, sw_r} > MAXW_C) ? MAXW_C[9:0] : sw_r;
  assign effh = ({3'b0, sh_r} > MAXH_C) ? MAXH_C[9:0] : sh_r;

  // ---------------- input unpack ----------------
  logic               in_fire;
  logic [1:0]         in_vi;
  logic signed [12:0] in_x, in_y;
  logic [30:0]        in_z;
  logic [31:0]        in_fill;
  logic [23:0]        in_ocol;
  logic               in_oon;

  assign in_vi   = in_tdata[1:0];
  assign in_x    = $signed(in_tdata[14:2]);
  assign in_y    = $signed(in_tdata[27:15]);
  assign in_z    = in_tdata[58:28];
  assign in_fill = in_tdata[90:59];
  assign in_ocol = in_tdata[114:91];
  assign in_oon  = in_tdata[115];
  assign in_fire = in_tvalid && in_tready;

  // ---------------- state ----------------
  rtdt_state_t state_r, state_nxt;

  logic signed [12:0] cx_r [3];
  logic signed [12:0] cy_r [3];
  logic [30:0]        cz_r [3];
  logic [31:0]        fill_r;
  logic [23:0]        ocol_r;
  logic               oon_r;

  logic [9:0]  x0_r, x1_r, y0_r, y1_r;
  logic [9:0]  px_r, py_r;
  logic        act_r;
  logic [19:0] band_r;
  logic signed [13:0]      dx1_r, dx2_r, dy1_r, dy2_r;
  logic signed [31:0]      dz1_r, dz2_r;
  logic signed [DET_W-1:0] det_r;
  logic signed [NX_W-1:0]  nx_r, ny_r;

  // per-pixel pipeline
  logic signed [13:0] ex_r [3];
  logic signed [13:0] ey_r [3];
  logic signed [13:0] tx_r, ty_r;
  logic [AW-1:0]      addr_r;
  logic               onscr_r, last_r, xend_r, idle_adv_r;
  logic signed [28:0] ab_r, bc_r, ca_r;
  logic signed [60:0] numx_r, numy_r;
  logic signed [NUM_W-1:0] num_r;
  logic               cov_r, outl_r, neg_r;

  // output register
  logic        out_valid_r;
  logic [8:0]  opx_r, opy_r;
  logic [31:0] ocolor_r;
  logic [31:0] odepth_r;
  logic        owe_r, olast_r;

  // depth store
  logic [31:0]   dmem [MEM_DEPTH];
  logic [31:0]   mem_rdata_r;
  logic          mem_we;
  logic [AW-1:0] mem_waddr;
  logic [31:0]   mem_wdata;
  logic [AW-1:0] clr_cnt_r;
  logic [30:0]   sweep_val_r;

  // divider
  logic             div_start, div_done;
  logic [DVD_W-1:0] dvd, quo;
  logic [DVS_W-1:0] dvs;
  logic [DET_W-1:0] absdet;
  logic [NUM_W-1:0] absnum;

  logic out_free, commit;

  assign out_free = !out_valid_r || out_tready;

  // ---------------- control ----------------
  always_comb begin
    state_nxt = state_r;
    in_tready = 1'b0;
    div_start = 1'b0;
    commit    = 1'b0;
    unique case (state_r)
      ST_CLEAR: begin
        if (clr_cnt_r == AW'(MEM_DEPTH - 1)) begin
          state_nxt = ST_IDLE;
        end
      end
      ST_IDLE: begin
        in_tready = 1'b1;
        if (in_tvalid) begin
          case (in_tuser)
            ACT_VERTEX:  state_nxt = (in_vi == LAST_CORNER) ? ST_SETUP0 : ST_IDLE;
            ACT_ADVANCE: state_nxt = act_r ? ST_PIX0 : ST_FIN;
            ACT_CLEAR:   state_nxt = ST_CLEAR;
            default:     state_nxt = ST_IDLE;
          endcase
        end
      end
      ST_SETUP0: state_nxt = ST_SETUP1;
      ST_SETUP1: state_nxt = ST_SETUP2;
      ST_SETUP2: state_nxt = ST_IDLE;
      ST_PIX0:   state_nxt = ST_PIX1;
      ST_PIX1:   state_nxt = ST_PIX2;
      ST_PIX2:   state_nxt = ST_PIX3;
      ST_PIX3:   state_nxt = (det_r == '0) ? ST_FIN : ST_PIX4;
      ST_PIX4: begin
        div_start = 1'b1;
        state_nxt = ST_DIV;
      end
      ST_DIV: begin
        if (div_done) begin
          state_nxt = ST_FIN;
        end
      end
      ST_FIN: begin
        if (out_free) begin
          commit    = 1'b1;
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_CLEAR;
    end else begin
      state_r <= state_nxt;
    end
  end

  // ---------------- setup arithmetic ----------------
  logic signed [12:0] xmin, xmax, ymin, ymax, xlo, xhi, ylo, yhi;
  logic signed [12:0] effw_s, effh_s;
  logic signed [13:0] dx1, dx2, dy1, dy2;
  logic signed [27:0] dp1, dp2;
  logic signed [45:0] sp1, sp2;

  always_comb begin
    xmin = cx_r[0];
    xmax = cx_r[0];
    ymin = cy_r[0];
    ymax = cy_r[0];
    for (int i = 1; i < 3; i++) begin
      if (cx_r[i] < xmin) xmin = cx_r[i];
      if (cx_r[i] > xmax) xmax = cx_r[i];
      if (cy_r[i] < ymin) ymin = cy_r[i];
      if (cy_r[i] > ymax) ymax = cy_r[i];
    end
    effw_s = $signed({3'b0, effw});
    effh_s = $signed({3'b0, effh});
    xlo = xmin[12] ? 13'sd0 : xmin;
    ylo = ymin[12] ? 13'sd0 : ymin;
    xhi = (xmax > effw_s) ? effw_s : xmax;
    yhi = (ymax > effh_s) ? effh_s : ymax;
    dx1 = 14'(cx_r[1]) - 14'(cx_r[0]);
    dx2 = 14'(cx_r[2]) - 14'(cx_r[1]);
    dy1 = 14'(cy_r[1]) - 14'(cy_r[0]);
    dy2 = 14'(cy_r[2]) - 14'(cy_r[1]);
    dp1 = dx1 * dy2;
    dp2 = dx2 * dy1;
    // plane numerators: nx in ST_SETUP1, ny in ST_SETUP2
    if (state_r == ST_SETUP1) begin
      sp1 = dy2_r * dz1_r;
      sp2 = dz2_r * dy1_r;
    end else begin
      sp1 = dx1_r * dz2_r;
      sp2 = dz1_r * dx2_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fill_r <= '0;
      ocol_r <= '0;
      oon_r  <= 1'b0;
      act_r  <= 1'b0;
      x0_r   <= '0;
      x1_r   <= '0;
      y0_r   <= '0;
      y1_r   <= '0;
      px_r   <= '0;
      py_r   <= '0;
      band_r <= '0;
      det_r  <= '0;
      nx_r   <= '0;
      ny_r   <= '0;
    end else begin
      if (in_fire && in_tuser == ACT_VERTEX && in_vi == LAST_CORNER) begin
        fill_r <= in_fill;
        ocol_r <= in_ocol;
        oon_r  <= in_oon;
      end
      if (state_r == ST_SETUP0) begin
        // setup abandons any scan in progress
        act_r <= (xlo < xhi) && (ylo < yhi);
        x0_r  <= xlo[9:0];
        x1_r  <= xhi[9:0];
        y0_r  <= ylo[9:0];
        y1_r  <= yhi[9:0];
        px_r  <= xlo[9:0];
        py_r  <= ylo[9:0];
        det_r <= DET_W'(dp1) - DET_W'(dp2);
      end
      if (state_r == ST_SETUP1) begin
        nx_r   <= NX_W'(sp1) - NX_W'(sp2);
        band_r <= act_r ? 20'(x1_r - x0_r) * 20'(y1_r - y0_r) : '0;
      end
      if (state_r == ST_SETUP2) begin
        ny_r <= NX_W'(sp1) - NX_W'(sp2);
      end
      if (commit && !idle_adv_r) begin
        if (last_r) begin
          act_r <= 1'b0;
        end else if (xend_r) begin
          px_r <= x0_r;
          py_r <= py_r + 10'd1;
        end else begin
          px_r <= px_r + 10'd1;
        end
      end
    end
  end

  // corners and deltas carry no reset
  always_ff @(posedge clk) begin
    if (in_fire && in_tuser == ACT_VERTEX && in_vi != 2'd3) begin
      cx_r[in_vi] <= in_x;
      cy_r[in_vi] <= in_y;
      cz_r[in_vi] <= in_z;
    end
    if (state_r == ST_SETUP0) begin
      dx1_r <= dx1;
      dx2_r <= dx2;
      dy1_r <= dy1;
      dy2_r <= dy2;
      dz1_r <= $signed({1'b0, cz_r[1]}) - $signed({1'b0, cz_r[0]});
      dz2_r <= $signed({1'b0, cz_r[2]}) - $signed({1'b0, cz_r[1]});
    end
  end

  // ---------------- pixel pipeline ----------------
  logic signed [13:0]  pxs, pys;
  logic [20:0]         addr_full;
  logic signed [35:0]  ab100, bc100, ca100, band_s;
  logic                cov_c;

  always_comb begin
    pxs       = $signed({4'b0, px_r});
    pys       = $signed({4'b0, py_r});
    addr_full = 21'(py_r) * 21'(effw) + 21'(px_r);
    ab100     = 36'(ab_r) * 36'sd100;
    bc100     = 36'(bc_r) * 36'sd100;
    ca100     = 36'(ca_r) * 36'sd100;
    band_s    = $signed({16'b0, band_r});
    cov_c     = !ab_r[28] && !bc_r[28] && !ca_r[28];
  end

  always_ff @(posedge clk) begin
    if (state_r == ST_IDLE) begin
      idle_adv_r <= !act_r;
    end
    if (state_r == ST_PIX0) begin
      for (int i = 0; i < 3; i++) begin
        ex_r[i] <= 14'(cx_r[i]) - pxs;
        ey_r[i] <= 14'(cy_r[i]) - pys;
      end
      tx_r    <= pxs - 14'(cx_r[2]);
      ty_r    <= pys - 14'(cy_r[2]);
      addr_r  <= AW'(addr_full);
      onscr_r <= (px_r < effw) && (py_r < effh);
      xend_r  <= ({1'b0, px_r} + 11'd1) >= {1'b0, x1_r};
      last_r  <= (({1'b0, px_r} + 11'd1) >= {1'b0, x1_r}) &&
                 (({1'b0, py_r} + 11'd1) >= {1'b0, y1_r});
    end
    if (state_r == ST_PIX1) begin
      ab_r <= 29'(ex_r[0] * ey_r[1]) - 29'(ey_r[0] * ex_r[1]);
      bc_r <= 29'(ex_r[1] * ey_r[2]) - 29'(ey_r[1] * ex_r[2]);
      ca_r <= 29'(ex_r[2] * ey_r[0]) - 29'(ey_r[2] * ex_r[0]);
    end
    if (state_r == ST_PIX2) begin
      numx_r <= tx_r * nx_r;
      numy_r <= ty_r * ny_r;
      cov_r  <= cov_c;
      outl_r <= oon_r && ((ab100 < band_s) || (bc100 < band_s) || (ca100 < band_s));
    end
    if (state_r == ST_PIX3) begin
      num_r <= NUM_W'(numx_r) + NUM_W'(numy_r);
    end
    if (state_r == ST_PIX4) begin
      neg_r <= num_r[NUM_W-1] ^ det_r[DET_W-1];
    end
  end

  // rounded division: q = floor((2|num| + |det|) / (2|det|))
  always_comb begin
    absdet = det_r[DET_W-1] ? DET_W'(-det_r) : DET_W'(det_r);
    absnum = num_r[NUM_W-1] ? NUM_W'(-num_r) : NUM_W'(num_r);
    dvd    = DVD_W'({absnum, 1'b0}) + DVD_W'(absdet);
    dvs    = {absdet, 1'b0};
  end

  rtdt_div #(
    .NW(DVD_W),
    .DW(DVS_W)
  ) u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .dividend (dvd),
    .divisor  (dvs),
    .done     (div_done),
    .quotient (quo)
  );

  // ---------------- depth and final decision ----------------
  logic signed [47:0] zd_sum;
  logic signed [34:0] zc35, qs, zq_sum;
  logic signed [31:0] z_fin;
  logic               we_c;
  logic [31:0]        color_c;

  always_comb begin
    zc35   = $signed({4'b0, cz_r[2]});
    zd_sum = 48'(num_r) * 48'sd50 + 48'(zc35);
    qs     = neg_r ? -$signed({2'b0, quo[32:0]}) : $signed({2'b0, quo[32:0]});
    zq_sum = zc35 + qs;
    if (det_r == '0) begin
      // flat determinant: depth = zC + 50 * numerator
      if (num_r > ZD_LIM) begin
        z_fin = 32'sh7FFF_FFFF;
      end else if (num_r < -ZD_LIM) begin
        z_fin = 32'sh8000_0000;
      end else if (zd_sum > 48'sh7FFF_FFFF) begin
        z_fin = 32'sh7FFF_FFFF;
      end else if (zd_sum < -48'sh8000_0000) begin
        z_fin = 32'sh8000_0000;
      end else begin
        z_fin = 32'(zd_sum);
      end
    end else if ((|quo[DVD_W-1:33]) || (zq_sum > 35'sh7FFF_FFFF) ||
                 (zq_sum < -35'sh8000_0000)) begin
      z_fin = (neg_r && (|quo[DVD_W-1:33] || zq_sum[34])) ? 32'sh8000_0000
                                                          : 32'sh7FFF_FFFF;
    end else begin
      z_fin = 32'(zq_sum);
    end
    we_c    = cov_r && onscr_r && (z_fin < $signed(mem_rdata_r));
    color_c = (cov_r && outl_r) ? {fill_r[31:24], ocol_r} : fill_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (commit) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (commit) begin
      if (idle_adv_r) begin
        opx_r    <= '0;
        opy_r    <= '0;
        ocolor_r <= '0;
        odepth_r <= '0;
        owe_r    <= 1'b0;
        olast_r  <= 1'b1;
      end else begin
        opx_r    <= px_r[8:0];
        opy_r    <= py_r[8:0];
        ocolor_r <= color_c;
        odepth_r <= z_fin;
        owe_r    <= we_c;
        olast_r  <= last_r;
      end
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tlast  = olast_r;
  assign out_tdata  = {5'b0, owe_r, odepth_r, ocolor_r, opy_r, opx_r};

  // ---------------- depth store ----------------
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clr_cnt_r   <= '0;
      sweep_val_r <= FAR_RESET;
    end else if (in_fire && in_tuser == ACT_CLEAR) begin
      clr_cnt_r   <= '0;
      sweep_val_r <= far_r;
    end else if (state_r == ST_CLEAR) begin
      clr_cnt_r <= clr_cnt_r + AW'(1);
    end
  end

  always_comb begin
    mem_we    = 1'b0;
    mem_waddr = addr_r;
    mem_wdata = z_fin;
    if (state_r == ST_CLEAR) begin
      mem_we    = 1'b1;
      mem_waddr = clr_cnt_r;
      mem_wdata = {1'b0, sweep_val_r};
    end else if (commit && !idle_adv_r && we_c) begin
      mem_we = 1'b1;
    end
  end

  // one pixel in flight at a time, so the read of addr_r never races its write
  always_ff @(posedge clk) begin
    if (mem_we) begin
      dmem[mem_waddr] <= mem_wdata;
    end
    mem_rdata_r <= dmem[addr_r];
  end

  // ---------------- checks ----------------
  a_mem_wr_state: assert property (@(posedge clk) disable iff (!rst_n)
    mem_we |-> (state_r == ST_CLEAR || state_r == ST_FIN))
    else $error("depth store written outside clear or commit");

  a_no_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
    in_tready |-> (state_r == ST_IDLE))
    else $error("input taken while busy");

  a_div_done_wait: assert property (@(posedge clk) disable iff (!rst_n)
    div_done |-> (state_r == ST_DIV))
    else $error("divider finished outside wait state");

  a_commit_slot: assert property (@(posedge clk) disable iff (!rst_n)
    commit |=> out_tvalid)
    else $error("committed word not presented");

endmodule

[test/tb_triangle_raster_depth_test.sv]
module tb_triangle_raster_depth_test
  import rtdt_pkg::*;
();
  timeunit 1ns;
  timeprecision 1ps;

  localparam int  SCR_W = DEF_MAX_WIDTH;
  localparam int  SCR_H = DEF_MAX_HEIGHT;
  localparam longint CYCLE_LIMIT = 8000000;
  localparam int  RANDOM_ITEMS = 1600;

  typedef struct {
    logic [8:0]  px;
    logic [8:0]  py;
    logic [31:0] color;
    logic [31:0] depth;
    logic        we;
    logic        last;
  } pixel_t;

  logic         clk = 1'b0;
  logic         rst_n = 1'b0;
  logic         in_tvalid = 1'b0;
  logic         in_tready;
  logic [119:0] in_tdata = '0;
  logic [1:0]   in_tuser = ACT_VERTEX;
  logic         out_tvalid;
  logic         out_tready = 1'b0;
  logic [87:0]  out_tdata;
  logic         out_tlast;
  logic         cfg_valid = 1'b0;
  logic         cfg_ready;
  logic [1:0]   cfg_index = REG_WIDTH;
  logic [30:0]  cfg_data = '0;

  triangle_raster_depth_test u_dut (.*);

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // predictor state
  longint  scr_w = 512, scr_h = 512, far_z = 13107200;
  longint  cx[3], cy[3], cz[3];
  logic [31:0] tri_fill;
  logic [23:0] tri_outline;
  bit      tri_outline_on;
  longint  grad_nx, grad_ny, grad_det;
  longint  box_x0, box_x1, box_y0, box_y1, box_area;
  longint  scan_x, scan_y;
  bit      scan_on;
  int      zbuf[SCR_W*SCR_H];

  pixel_t  pending_pixels[$];
  int      fail_count = 0;
  longint  cycle_count = 0;
  bit      quiet = 1'b0;
  int      rx_hold = 0;
  int      items_sent = 0;

  function automatic longint eff_w();
    return (scr_w > SCR_W) ? SCR_W : scr_w;
  endfunction

  function automatic longint eff_h();
    return (scr_h > SCR_H) ? SCR_H : scr_h;
  endfunction

  function automatic longint sat32(longint v);
    if (v > 64'sd2147483647) return 64'sd2147483647;
    if (v < -64'sd2147483648) return -64'sd2147483648;
    return v;
  endfunction

  function automatic longint edge_cross(int p, int q, longint px, longint py);
    return (cx[p] - px) * (cy[q] - py) - (cy[p] - py) * (cx[q] - px);
  endfunction

  function automatic longint plane_depth(longint px, longint py);
    longint num, d, q;
    num = (px - cx[2]) * grad_nx + (py - cy[2]) * grad_ny;
    d = grad_det;
    if (d == 0) begin
      if (num > (64'sd1 << 40)) return 64'sd2147483647;
      if (num < -(64'sd1 << 40)) return -64'sd2147483648;
      return sat32(cz[2] + 50 * num);
    end
    if (d < 0) begin
      d = -d;
      num = -num;
    end
    if (num >= 0) q = (2 * num + d) / (2 * d);
    else q = -((-2 * num + d) / (2 * d));
    return sat32(cz[2] + q);
  endfunction

  function automatic void triangle_setup();
    longint xmin, xmax, ymin, ymax;
    xmin = cx[0]; xmax = cx[0]; ymin = cy[0]; ymax = cy[0];
    for (int i = 1; i < 3; i++) begin
      if (cx[i] < xmin) xmin = cx[i];
      if (cx[i] > xmax) xmax = cx[i];
      if (cy[i] < ymin) ymin = cy[i];
      if (cy[i] > ymax) ymax = cy[i];
    end
    if (xmin < 0) xmin = 0;
    if (ymin < 0) ymin = 0;
    if (xmax > eff_w()) xmax = eff_w();
    if (ymax > eff_h()) ymax = eff_h();
    box_x0 = xmin; box_x1 = xmax; box_y0 = ymin; box_y1 = ymax;
    grad_det = (cx[1] - cx[0]) * (cy[2] - cy[1]) - (cx[2] - cx[1]) * (cy[1] - cy[0]);
    grad_nx = (cy[2] - cy[1]) * (cz[1] - cz[0]) - (cz[2] - cz[1]) * (cy[1] - cy[0]);
    grad_ny = (cx[1] - cx[0]) * (cz[2] - cz[1]) - (cz[1] - cz[0]) * (cx[2] - cx[1]);
    scan_x = xmin;
    scan_y = ymin;
    scan_on = (xmin < xmax) && (ymin < ymax);
    box_area = scan_on ? (xmax - xmin) * (ymax - ymin) : 0;
  endfunction

  function automatic void predict_word(logic [1:0] act, logic [119:0] d);
    pixel_t r;
    longint ab, bc, ca, z;
    int vi;
    bit covered, fin;
    if (act == ACT_VERTEX) begin
      vi = int'(d[1:0]);
      if (vi > LAST_CORNER) return;
      cx[vi] = longint'($signed(d[14:2]));
      cy[vi] = longint'($signed(d[27:15]));
      cz[vi] = longint'(d[58:28]);
      if (vi == LAST_CORNER) begin
        tri_fill = d[90:59];
        tri_outline = d[114:91];
        tri_outline_on = d[115];
        triangle_setup();
      end
      return;
    end
    if (act == ACT_CLEAR) begin
      foreach (zbuf[k]) zbuf[k] = int'(far_z);
      return;
    end
    if (act != ACT_ADVANCE) return;
    r = '{default: '0};
    if (!scan_on) begin
      r.last = 1'b1;
      pending_pixels = {pending_pixels, r};
      return;
    end
    ab = edge_cross(0, 1, scan_x, scan_y);
    bc = edge_cross(1, 2, scan_x, scan_y);
    ca = edge_cross(2, 0, scan_x, scan_y);
    covered = (ab >= 0) && (bc >= 0) && (ca >= 0);
    z = plane_depth(scan_x, scan_y);
    fin = (scan_x + 1 >= box_x1) && (scan_y + 1 >= box_y1);
    r.color = tri_fill;
    if (covered) begin
      if (tri_outline_on && (100 * ab < box_area || 100 * bc < box_area ||
                             100 * ca < box_area))
        r.color = {tri_fill[31:24], tri_outline};
      if (scan_x < eff_w() && scan_y < eff_h()) begin
        if (z < longint'(zbuf[scan_x + scan_y * eff_w()])) begin
          zbuf[scan_x + scan_y * eff_w()] = int'(z);
          r.we = 1'b1;
        end
      end
    end
    r.px = scan_x[8:0];
    r.py = scan_y[8:0];
    r.depth = z[31:0];
    r.last = fin;
    pending_pixels = {pending_pixels, r};
    if (fin) scan_on = 1'b0;
    else if (scan_x + 1 >= box_x1) begin
      scan_x = box_x0;
      scan_y = scan_y + 1;
    end else scan_x = scan_x + 1;
  endfunction

  // cycle limit
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("triangle_raster_depth_test regression: fail");
      $finish;
    end
  end

  // receiver: random bursts of backpressure plus an optional long hold
  int rx_burst = 0;
  always @(posedge clk) begin
    if (rx_hold > 0) begin
      out_tready <= 1'b0;
      rx_hold <= rx_hold - 1;
    end else if (rx_burst > 0) begin
      out_tready <= 1'b0;
      rx_burst <= rx_burst - 1;
    end else if (!quiet && $urandom_range(0, 5) == 0) begin
      out_tready <= 1'b0;
      rx_burst <= $urandom_range(0, 3);
    end else out_tready <= 1'b1;
  end

  // result checker
  always @(posedge clk) begin
    pixel_t e;
    if (rst_n && out_tvalid && out_tready) begin
      if (pending_pixels.size() == 0) begin
        fail_count++;
        $display("%0t: unexpected pixel word, expected none, actual %h last %b",
                 $time, out_tdata, out_tlast);
      end else begin
        e = pending_pixels.pop_front();
        if (out_tdata[8:0] !== e.px || out_tdata[17:9] !== e.py ||
            out_tdata[49:18] !== e.color || out_tdata[81:50] !== e.depth ||
            out_tdata[82] !== e.we || out_tlast !== e.last) begin
          fail_count++;
          $display("%0t: exp %0d %0d %h %h %b %b act %0d %0d %h %h %b %b",
                   $time, e.px, e.py, e.color, e.depth, e.we, e.last,
                   out_tdata[8:0], out_tdata[17:9], out_tdata[49:18],
                   out_tdata[81:50], out_tdata[82], out_tlast);
        end
      end
    end
  end

  // tvalid stays high after a word; drain drops it when the sender goes quiet
  task automatic send_word(logic [1:0] act, logic [1:0] vi, int x, int y,
                           logic [30:0] z, logic [31:0] fill, logic [23:0] outl,
                           logic oon);
    logic [119:0] d;
    d = {4'b0, oon, outl, fill, z, y[12:0], x[12:0], vi};
    if (!quiet && $urandom_range(0, 4) == 0) begin
      in_tvalid <= 1'b0;
      repeat ($urandom_range(1, 4)) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata <= d;
    in_tuser <= act;
    do @(posedge clk); while (!in_tready);
    predict_word(act, d);
    items_sent++;
  endtask

  task automatic advance(int n);
    repeat (n) send_word(ACT_ADVANCE, 2'd0, 0, 0, '0, '0, '0, 1'b0);
  endtask

  task automatic load_triangle(int x0, int y0, logic [30:0] z0, int x1, int y1,
                               logic [30:0] z1, int x2, int y2, logic [30:0] z2,
                               logic [31:0] fill, logic [23:0] outl, logic oon);
    send_word(ACT_VERTEX, 2'd0, x0, y0, z0, $urandom, 24'($urandom), 1'($urandom));
    send_word(ACT_VERTEX, 2'd1, x1, y1, z1, $urandom, 24'($urandom), 1'($urandom));
    send_word(ACT_VERTEX, LAST_CORNER, x2, y2, z2, fill, outl, oon);
  endtask

  task automatic drain(int extra);
    in_tvalid <= 1'b0;
    while (pending_pixels.size() != 0) @(posedge clk);
    repeat (extra) @(posedge clk);
  endtask

  task automatic write_reg(logic [1:0] idx, logic [30:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    case (idx)
      REG_WIDTH:  scr_w = longint'(val[9:0]);
      REG_HEIGHT: scr_h = longint'(val[9:0]);
      REG_FAR:    far_z = longint'(val);
      default: ;
    endcase
    @(posedge clk);
  endtask

  task automatic clear_store();
    send_word(ACT_CLEAR, 2'd0, 0, 0, '0, '0, '0, 1'b0);
    advance(1);  // its result marks the end of the sweep
  endtask

  task automatic test_no_scan();
    advance(2);
    send_word(2'd3, 2'd0, 0, 0, '0, '0, '0, 1'b0);
    send_word(ACT_VERTEX, 2'd3, -1, -1, 31'h7fffffff, '1, '1, 1'b1);
    drain(20);
  endtask

  task automatic test_field_extremes();
    load_triangle(-4096, -4096, 31'h0, 4095, -4096, 31'h7fffffff,
                  -4096, 4095, 31'h0, 32'hffffffff, 24'hffffff, 1'b1);
    advance(4);
    load_triangle(0, 0, 31'h7fffffff, 4095, 4095, 31'h0, 0, 4095,
                  31'h7fffffff, 32'h0, 24'h0, 1'b0);
    advance(3);
    drain(20);
  endtask

  task automatic test_small_outlined();
    load_triangle(10, 10, 31'd100000, 20, 12, 31'd300000, 12, 19, 31'd50000,
                  32'h80a0b0c0, 24'h123456, 1'b1);
    advance(100);
    drain(20);
  endtask

  task automatic test_flat_triangle();
    // collinear corners, determinant is zero
    load_triangle(5, 5, 31'd1000, 8, 8, 31'd9000, 11, 11, 31'd20, 32'h11223344,
                  24'h778899, 1'b1);
    advance(8);
    drain(20);
  endtask

  task automatic test_config_sweep();
    write_reg(REG_WIDTH, 31'd1);
    write_reg(REG_HEIGHT, 31'd1);
    load_triangle(-3, -3, 31'd5, 6, 0, 31'd6, 0, 6, 31'd7, 32'hdeadbeef, 24'h0, 1'b0);
    advance(2);
    drain(20);
    write_reg(REG_WIDTH, 31'd512);
    write_reg(REG_HEIGHT, 31'd512);
    write_reg(REG_FAR, 31'd0);
    clear_store();
    load_triangle(1, 1, 31'd0, 5, 1, 31'd0, 1, 5, 31'd0, 32'h1, 24'h2, 1'b1);
    advance(12);
    drain(20);
    write_reg(REG_FAR, 31'h7fffffff);
    clear_store();
    drain(20);
    // shrink the screen in the middle of a scan
    load_triangle(500, 500, 31'd10, 511, 500, 31'd20, 500, 511, 31'd30,
                  32'hcafef00d, 24'habcdef, 1'b1);
    advance(5);
    drain(20);
    write_reg(REG_WIDTH, 31'd502);
    write_reg(REG_HEIGHT, 31'd505);
    advance(20);
    drain(20);
    write_reg(REG_WIDTH, 31'd512);
    write_reg(REG_HEIGHT, 31'd512);
  endtask

  task automatic test_backpressure();
    load_triangle(30, 30, 31'd4000, 45, 31, 31'd8000, 31, 44, 31'd100, $urandom,
                  24'($urandom), 1'b1);
    rx_hold = 400;
    advance(40);
    drain(0);  // sender waits for every pixel word
  endtask

  task automatic random_triangle();
    int bx, by, spread, n;
    int x[3], y[3];
    logic [30:0] z[3], zb;
    bx = $urandom_range(0, 520) - 8;
    by = $urandom_range(0, 520) - 8;
    spread = ($urandom_range(0, 3) == 0) ? 20 : 8;
    zb = 31'($urandom);
    for (int i = 0; i < 3; i++) begin
      if ($urandom_range(0, 19) == 0) begin
        x[i] = $urandom_range(0, 8191) - 4096;
        y[i] = $urandom_range(0, 8191) - 4096;
      end else begin
        x[i] = bx + $urandom_range(0, 2 * spread) - spread;
        y[i] = by + $urandom_range(0, 2 * spread) - spread;
      end
      z[i] = ($urandom_range(0, 4) == 0) ? 31'($urandom)
                                         : 31'(zb + $urandom_range(0, 200000));
    end
    if ($urandom_range(0, 9) == 0) begin
      x[2] = 2 * x[1] - x[0];
      y[2] = 2 * y[1] - y[0];
    end
    load_triangle(x[0], y[0], z[0], x[1], y[1], z[1], x[2], y[2], z[2],
                  $urandom, 24'($urandom), 1'($urandom_range(0, 1)));
    if (scan_on && box_area <= 80) n = int'(box_area) + $urandom_range(0, 2);
    else n = $urandom_range(1, 30);
    advance(n);
  endtask

  task automatic test_random();
    int target;
    bit mid_clear_done;
    target = items_sent + RANDOM_ITEMS;
    mid_clear_done = 1'b0;
    while (items_sent < target) begin
      if (items_sent > target - 200) quiet = 1'b1;
      case ($urandom_range(0, 19))
        0: send_word(2'd3, 2'($urandom), $urandom, $urandom, 31'($urandom), $urandom,
                     24'($urandom), 1'($urandom));
        1: send_word(ACT_VERTEX, 2'd3, $urandom, $urandom, 31'($urandom), $urandom,
                     24'($urandom), 1'($urandom));
        2: send_word(ACT_VERTEX, 2'($urandom_range(0, 1)), $urandom, $urandom,
                     31'($urandom), $urandom, 24'($urandom), 1'($urandom));
        3: advance($urandom_range(1, 3));
        default: random_triangle();
      endcase
      if (!mid_clear_done && items_sent > target - 1000) begin
        mid_clear_done = 1'b1;
        drain(20);
        write_reg(REG_FAR, 31'($urandom));
        clear_store();
      end
    end
  endtask

  initial begin
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    foreach (zbuf[k]) zbuf[k] = int'(far_z);
    test_no_scan();
    test_field_extremes();
    test_small_outlined();
    test_flat_triangle();
    test_config_sweep();
    test_backpressure();
    test_random();
    drain(200);
    if (fail_count == 0) $display("triangle_raster_depth_test regression: pass");
    else $display("triangle_raster_depth_test regression: fail");
    $finish;
  end

endmodule
